// File: src/dfa_pkg.sv
// ----------------------------------------------------------------------------
// dfa_pkg
// Shared constants and types for the table-driven automaton acceptor.
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int NUM_STATES  = 64;
    localparam int NUM_SYMBOLS = 64;
    localparam int FIELD_W     = 6;

    // transition table: one entry per (state, symbol), {valid, dest}
    localparam int TT_DEPTH = NUM_STATES * NUM_SYMBOLS;
    localparam int TT_AW    = $clog2(TT_DEPTH);
    localparam int TT_W     = FIELD_W + 1;

    // final-mark memory: one bit per state
    localparam int FS_AW = $clog2(NUM_STATES);

    typedef logic [FIELD_W-1:0] t_field;

    typedef enum logic [1:0] {
        MODE_WR_TRANS  = 2'd0,
        MODE_SET_FINAL = 2'd1,
        MODE_STEP      = 2'd2,
        MODE_EMPTY     = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TABLE,
        ST_FINAL
    } t_state;

endpackage

// File: src/dfa_ram.sv
// ----------------------------------------------------------------------------
// dfa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/table_driven_dfa_acceptor.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_acceptor
// Programmable deterministic automaton with a transition table and final marks
// held in synchronous RAMs.
// ----------------------------------------------------------------------------
// Sequence: a step reads the table, then the final mark of the new state, and
// then registers its result; an empty-word query reads only the final mark.
// The input is stalled until that result is registered; table and final-mark
// writes are taken one per cycle while idle and are stored at their transfer.
// Reset: a clearing pass wipes both RAMs; the input is stalled during it, the
// configuration port stays open.
module table_driven_dfa_acceptor (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  dfa_pkg::t_field       i_cfg_initial_state,
    // input items
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [1:0]            i_mode,
    input  dfa_pkg::t_field       i_from_state,
    input  dfa_pkg::t_field       i_symbol,
    input  dfa_pkg::t_field       i_to_state,
    input  logic                  i_entry_valid,
    input  logic                  i_last_symbol,
    // results
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dfa_pkg::t_field       o_new_state,
    output logic                  o_is_final,
    output logic                  o_word_done
);

    import dfa_pkg::*;

    t_state             r_state, n_state;
    logic [TT_AW-1:0]   r_clr_cnt, n_clr_cnt;
    t_field             r_init, n_init;
    t_field             r_cur, n_cur;
    logic               r_in_word, n_in_word;
    t_field             r_base, n_base;
    logic               r_last, n_last;
    logic               r_tt_hit, n_tt_hit;
    logic               r_fs_hit, n_fs_hit;
    logic               r_out_valid, n_out_valid;
    t_field             r_out_state, n_out_state;
    logic               r_out_final, n_out_final;
    logic               r_out_done, n_out_done;

    logic               in_xfer;
    t_mode              mode;
    t_field             cur;
    t_field             new_st;

    logic               tt_we, tt_re;
    logic [TT_AW-1:0]   tt_waddr, tt_raddr;
    logic [TT_W-1:0]    tt_wdata, tt_rdata;
    logic               fs_we, fs_re;
    logic [FS_AW-1:0]   fs_waddr, fs_raddr;
    logic [0:0]         fs_wdata, fs_rdata;

    dfa_ram #(.WIDTH(TT_W), .DEPTH(TT_DEPTH)) u_tt_ram (
        .i_clk   (i_clk),
        .i_we    (tt_we),
        .i_waddr (tt_waddr),
        .i_wdata (tt_wdata),
        .i_re    (tt_re),
        .i_raddr (tt_raddr),
        .o_rdata (tt_rdata)
    );

    dfa_ram #(.WIDTH(1), .DEPTH(NUM_STATES)) u_fs_ram (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (fs_re),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign mode        = t_mode'(i_mode);
    assign cur         = r_in_word ? r_cur : r_init;
    assign new_st      = (r_tt_hit && tt_rdata[FIELD_W]) ? tt_rdata[FIELD_W-1:0] : r_base;

    assign o_out_valid = r_out_valid;
    assign o_new_state = r_out_state;
    assign o_is_final  = r_out_final;
    assign o_word_done = r_out_done;

    always_comb begin
        n_state     = r_state;
        n_clr_cnt   = r_clr_cnt;
        n_init      = i_cfg_valid ? i_cfg_initial_state : r_init;
        n_cur       = r_cur;
        n_in_word   = r_in_word;
        n_base      = r_base;
        n_last      = r_last;
        n_tt_hit    = r_tt_hit;
        n_fs_hit    = r_fs_hit;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_state = r_out_state;
        n_out_final = r_out_final;
        n_out_done  = r_out_done;

        tt_we    = 1'b0;
        tt_waddr = TT_AW'(i_from_state) * TT_AW'(NUM_SYMBOLS) + TT_AW'(i_symbol);
        tt_wdata = {i_entry_valid, (i_entry_valid ? i_to_state : t_field'(0))};
        tt_re    = 1'b0;
        tt_raddr = TT_AW'(cur) * TT_AW'(NUM_SYMBOLS) + TT_AW'(i_symbol);
        fs_we    = 1'b0;
        fs_waddr = FS_AW'(i_from_state);
        fs_wdata = i_entry_valid;
        fs_re    = 1'b0;
        fs_raddr = FS_AW'(r_init);

        case (r_state)
            ST_CLEAR: begin
                tt_we     = 1'b1;
                tt_waddr  = r_clr_cnt;
                tt_wdata  = '0;
                fs_we     = (int'(r_clr_cnt) < NUM_STATES);
                fs_waddr  = FS_AW'(r_clr_cnt);
                fs_wdata  = 1'b0;
                n_clr_cnt = r_clr_cnt + TT_AW'(1);
                if (r_clr_cnt == TT_AW'(TT_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    case (mode)
                        MODE_WR_TRANS: begin
                            tt_we = (int'(i_from_state) < NUM_STATES)
                                 && (int'(i_symbol) < NUM_SYMBOLS)
                                 && (int'(i_to_state) < NUM_STATES);
                        end
                        MODE_SET_FINAL: begin
                            fs_we = (int'(i_from_state) < NUM_STATES);
                        end
                        MODE_STEP: begin
                            // a closed word restarts from the initial state
                            n_base   = cur;
                            n_tt_hit = (int'(cur) < NUM_STATES)
                                    && (int'(i_symbol) < NUM_SYMBOLS);
                            tt_re    = n_tt_hit;
                            n_last   = i_last_symbol;
                            n_state  = ST_TABLE;
                        end
                        MODE_EMPTY: begin
                            n_base   = r_init;
                            n_fs_hit = (int'(r_init) < NUM_STATES);
                            fs_re    = n_fs_hit;
                            n_last   = 1'b1;
                            n_state  = ST_FINAL;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_TABLE: begin
                n_cur     = new_st;
                n_in_word = !r_last;
                n_base    = new_st;
                n_fs_hit  = (int'(new_st) < NUM_STATES);
                fs_re     = n_fs_hit;
                fs_raddr  = FS_AW'(new_st);
                n_state   = ST_FINAL;
            end
            ST_FINAL: begin
                // wait here while the previous result is still stalled
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_out_state = r_base;
                    n_out_final = r_fs_hit && fs_rdata[0];
                    n_out_done  = r_last;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_cnt   <= '0;
            r_init      <= '0;
            r_cur       <= '0;
            r_in_word   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_init      <= n_init;
            r_cur       <= n_cur;
            r_in_word   <= n_in_word;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_last      <= n_last;
        r_tt_hit    <= n_tt_hit;
        r_fs_hit    <= n_fs_hit;
        r_out_state <= n_out_state;
        r_out_final <= n_out_final;
        r_out_done  <= n_out_done;
    end

    a_clear_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> o_in_stall)
        else $error("input not stalled during clearing pass");

    a_last_closes_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TABLE && r_last) |=> !r_in_word)
        else $error("closing step left the word open");

    a_result_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_FINAL)
        else $error("result raised outside final-mark stage");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL && o_out_valid && i_out_stall) |=> r_state == ST_FINAL)
        else $error("result overwritten while output stalled");

endmodule

// File: tb/sv/dfa_acceptor_checker.sv
// ----------------------------------------------------------------------------
// dfa_acceptor_checker
// Watches the configuration, input and result channels of the automaton
// acceptor, keeps its own copy of the transition table, final marks and word
// walk, and compares every result transfer with the oldest predicted one.
// ----------------------------------------------------------------------------
module dfa_acceptor_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_valid,
    input  logic            i_cfg_ready,
    input  dfa_pkg::t_field i_cfg_initial_state,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  logic [1:0]      i_mode,
    input  dfa_pkg::t_field i_from_state,
    input  dfa_pkg::t_field i_symbol,
    input  dfa_pkg::t_field i_to_state,
    input  logic            i_entry_valid,
    input  logic            i_last_symbol,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  dfa_pkg::t_field i_new_state,
    input  logic            i_is_final,
    input  logic            i_word_done,
    output int              o_fail_count,
    output int              o_pending,
    output int              o_item_count,
    output int              o_result_count,
    output int              o_word_count,
    output int              o_accept_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import dfa_pkg::*;

    typedef struct packed {
        t_field new_state;
        logic   is_final;
        logic   word_done;
    } t_dfa_result;

    logic        edge_defined [TT_DEPTH];
    t_field      edge_dest    [TT_DEPTH];
    logic        accepting    [NUM_STATES];
    t_field      walk_state;
    logic        word_open;
    t_field      start_state;
    t_dfa_result pending_verdicts [$];

    // 6-bit fields are always below 64 states and 64 symbols, so no range drops
    function automatic bit advance_automaton(input t_mode mode, input t_field from,
                                             input t_field sym, input t_field dest,
                                             input logic ev, input logic last,
                                             output t_dfa_result res);
        int idx;
        idx = int'(from) * NUM_SYMBOLS + int'(sym);
        res = '0;
        case (mode)
            MODE_WR_TRANS: begin
                edge_defined[idx] = ev;
                edge_dest[idx]    = ev ? dest : '0;
                return 1'b0;
            end
            MODE_SET_FINAL: begin
                accepting[from] = ev;
                return 1'b0;
            end
            MODE_STEP: begin
                // the initial state is only picked up when a word starts
                if (!word_open) begin
                    walk_state = start_state;
                    word_open  = 1'b1;
                end
                idx = int'(walk_state) * NUM_SYMBOLS + int'(sym);
                if (edge_defined[idx]) begin
                    walk_state = edge_dest[idx];
                end
                if (last) begin
                    word_open = 1'b0;
                end
                res = '{walk_state, accepting[walk_state], last};
                return 1'b1;
            end
            default: begin
                // empty word leaves an open word alone
                res = '{start_state, accepting[start_state], 1'b1};
                return 1'b1;
            end
        endcase
    endfunction

    function automatic void check_field(input string field, input int want, input int got);
        if (want != got) begin
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            o_fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_dfa_result want_res;
        t_dfa_result got_res;
        if (!i_rst_n) begin
            for (int i = 0; i < TT_DEPTH; i++) begin
                edge_defined[i] = 1'b0;
                edge_dest[i]    = '0;
            end
            for (int i = 0; i < NUM_STATES; i++) begin
                accepting[i] = 1'b0;
            end
            walk_state  = '0;
            word_open   = 1'b0;
            start_state = '0;
            pending_verdicts.delete();
            o_fail_count   = 0;
            o_item_count   = 0;
            o_result_count = 0;
            o_word_count   = 0;
            o_accept_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                start_state = i_cfg_initial_state;
            end
            if (i_out_valid && !i_out_stall) begin
                got_res = '{i_new_state, i_is_final, i_word_done};
                o_result_count++;
                if (got_res.word_done) begin
                    o_word_count++;
                    if (got_res.is_final) begin
                        o_accept_count++;
                    end
                end
                if (pending_verdicts.size() == 0) begin
                    $display("%0t ns: unexpected result, expected none, actual state %0d final %0d done %0d",
                             $time, got_res.new_state, got_res.is_final, got_res.word_done);
                    o_fail_count++;
                end else begin
                    want_res = pending_verdicts.pop_front();
                    check_field("new_state", want_res.new_state, got_res.new_state);
                    check_field("is_final", want_res.is_final, got_res.is_final);
                    check_field("word_done", want_res.word_done, got_res.word_done);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                o_item_count++;
                if (advance_automaton(t_mode'(i_mode), i_from_state, i_symbol, i_to_state,
                                      i_entry_valid, i_last_symbol, want_res)) begin
                    pending_verdicts = {pending_verdicts, want_res};
                end
            end
        end
        o_pending = pending_verdicts.size();
    end

endmodule

// File: tb/sv/table_driven_dfa_acceptor_test.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_acceptor_test
// Drives programming, word steps and empty-word queries into the automaton
// acceptor under three idle profiles and one long output hold-off; the
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module table_driven_dfa_acceptor_test;
    timeunit 1ns;
    timeprecision 1ps;

    import dfa_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int PHASE_ITEMS   = 640;
    localparam int BURST_ITEMS   = 60;

    logic       clk         = 1'b0;
    logic       rst_n       = 1'b0;
    logic       cfg_valid   = 1'b0;
    logic       cfg_ready;
    t_field     cfg_data    = '0;
    logic       in_valid    = 1'b0;
    logic       in_stall;
    logic [1:0] mode_q      = '0;
    t_field     from_q      = '0;
    t_field     symbol_q    = '0;
    t_field     to_q        = '0;
    logic       ev_q        = 1'b0;
    logic       last_q      = 1'b0;
    logic       out_valid;
    logic       out_stall   = 1'b0;
    t_field     new_state;
    logic       is_final;
    logic       word_done;

    int     fail_count;
    int     pending;
    int     item_count;
    int     result_count;
    int     word_count;
    int     accept_count;
    int     src_idle_pct  = 0;
    int     sink_idle_pct = 0;
    logic   hold_start    = 1'b0;
    logic   hold_active   = 1'b0;
    t_field start_cfg     = '0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    table_driven_dfa_acceptor u_top (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .o_cfg_ready         (cfg_ready),
        .i_cfg_initial_state (cfg_data),
        .i_in_valid          (in_valid),
        .o_in_stall          (in_stall),
        .i_mode              (mode_q),
        .i_from_state        (from_q),
        .i_symbol            (symbol_q),
        .i_to_state          (to_q),
        .i_entry_valid       (ev_q),
        .i_last_symbol       (last_q),
        .o_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .o_new_state         (new_state),
        .o_is_final          (is_final),
        .o_word_done         (word_done)
    );

    dfa_acceptor_checker u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_valid         (cfg_valid),
        .i_cfg_ready         (cfg_ready),
        .i_cfg_initial_state (cfg_data),
        .i_in_valid          (in_valid),
        .i_in_stall          (in_stall),
        .i_mode              (mode_q),
        .i_from_state        (from_q),
        .i_symbol            (symbol_q),
        .i_to_state          (to_q),
        .i_entry_valid       (ev_q),
        .i_last_symbol       (last_q),
        .i_out_valid         (out_valid),
        .i_out_stall         (out_stall),
        .i_new_state         (new_state),
        .i_is_final          (is_final),
        .i_word_done         (word_done),
        .o_fail_count        (fail_count),
        .o_pending           (pending),
        .o_item_count        (item_count),
        .o_result_count      (result_count),
        .o_word_count        (word_count),
        .o_accept_count      (accept_count)
    );

    // receiver back-pressure
    always @(negedge clk) begin
        out_stall <= hold_active || ($urandom_range(99) < sink_idle_pct);
    end

    // long output hold-off so the block fills up and stalls its input
    initial begin : output_hold
        wait (hold_start);
        @(posedge clk);
        hold_active <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_active <= 1'b0;
    end

    initial begin : watchdog
        #2_000_000;
        $display("TEST FAILED");
        $finish;
    end

    task automatic push_item(input t_mode mode, input t_field from, input t_field sym,
                             input t_field dest, input logic ev, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode_q   <= mode;
        from_q   <= from;
        symbol_q <= sym;
        to_q     <= dest;
        ev_q     <= ev;
        last_q   <= last;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic settle_block();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_start_state(input t_field value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        start_cfg  = value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // mostly a small cluster of states around the start state and a few
    // symbols so that walks run over defined transitions
    task automatic push_random_item();
        int     pick;
        bit     narrow;
        t_mode  mode;
        t_field from;
        t_field sym;
        t_field dest;
        logic   ev;
        logic   last;
        pick   = $urandom_range(99);
        narrow = ($urandom_range(3) != 0);
        from   = narrow ? t_field'(start_cfg + $urandom_range(7)) : t_field'($urandom_range(63));
        dest   = narrow ? t_field'(start_cfg + $urandom_range(7)) : t_field'($urandom_range(63));
        sym    = narrow ? t_field'($urandom_range(7)) : t_field'($urandom_range(63));
        ev     = $urandom_range(1);
        last   = $urandom_range(1);
        if (pick < 22) begin
            mode = MODE_WR_TRANS;
            ev   = ($urandom_range(9) != 0);
        end else if (pick < 32) begin
            mode = MODE_SET_FINAL;
        end else if (pick < 90) begin
            mode = MODE_STEP;
            last = ($urandom_range(5) == 0);
        end else begin
            mode = MODE_EMPTY;
        end
        push_item(mode, from, sym, dest, ev, last);
    endtask

    initial begin : stimulus
        t_field phase_cfg [3];
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: word start, undefined symbols, edits mid-word, empty words
        src_idle_pct  = 20;
        sink_idle_pct = 20;
        write_start_state(6'd0);
        push_item(MODE_EMPTY, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1);
        push_item(MODE_STEP, 6'd0, 6'd5, 6'd0, 1'b0, 1'b0);
        push_item(MODE_WR_TRANS, 6'd0, 6'd5, 6'd63, 1'b1, 1'b0);
        push_item(MODE_WR_TRANS, 6'd63, 6'd0, 6'd42, 1'b1, 1'b0);
        push_item(MODE_SET_FINAL, 6'd63, 6'd0, 6'd0, 1'b1, 1'b0);
        push_item(MODE_STEP, 6'd0, 6'd5, 6'd0, 1'b0, 1'b0);
        push_item(MODE_EMPTY, 6'd0, 6'd0, 6'd0, 1'b0, 1'b0);
        push_item(MODE_STEP, 6'd0, 6'd0, 6'd0, 1'b0, 1'b1);
        push_item(MODE_STEP, 6'd0, 6'd63, 6'd0, 1'b0, 1'b0);
        // start state changes while a word is open
        settle_block();
        write_start_state(6'd63);
        push_item(MODE_STEP, 6'd0, 6'd5, 6'd0, 1'b0, 1'b1);
        push_item(MODE_STEP, 6'd0, 6'd0, 6'd0, 1'b0, 1'b1);
        push_item(MODE_EMPTY, 6'd0, 6'd0, 6'd0, 1'b0, 1'b0);
        push_item(MODE_WR_TRANS, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1);
        push_item(MODE_STEP, 6'd63, 6'd63, 6'd63, 1'b1, 1'b1);
        push_item(MODE_WR_TRANS, 6'd0, 6'd5, 6'd63, 1'b0, 1'b0);
        push_item(MODE_SET_FINAL, 6'd63, 6'd0, 6'd0, 1'b0, 1'b0);
        push_item(MODE_STEP, 6'd0, 6'd0, 6'd0, 1'b0, 1'b0);
        push_item(MODE_STEP, 6'd42, 6'd63, 6'd0, 1'b0, 1'b1);
        settle_block();
        write_start_state(6'd0);
        push_item(MODE_STEP, 6'd0, 6'd5, 6'd0, 1'b0, 1'b1);

        phase_cfg[0] = t_field'($urandom_range(62, 1));
        phase_cfg[1] = 6'd63;
        phase_cfg[2] = 6'd0;
        for (int phase = 0; phase < 3; phase++) begin
            settle_block();
            write_start_state(phase_cfg[phase]);
            src_idle_pct  = (phase == 0) ? 9 : (phase == 1) ? 78 : 0;
            sink_idle_pct = (phase == 0) ? 78 : (phase == 1) ? 9 : 0;
            if (phase == 2) begin
                hold_start = 1'b1;
                repeat (BURST_ITEMS) push_random_item();
            end
            repeat (PHASE_ITEMS) push_random_item();
        end

        settle_block();
        $display("run covered %0d input transfers and %0d results, %0d words closed, %0d accepted",
                 item_count, result_count, word_count, accept_count);
        $display("three idle profiles, start states 0, 63 and %0d, one long output hold-off",
                 phase_cfg[0]);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: table_driven_dfa_acceptor.f
src/dfa_pkg.sv
src/dfa_ram.sv
src/table_driven_dfa_acceptor.sv
tb/sv/dfa_acceptor_checker.sv
tb/sv/table_driven_dfa_acceptor_test.sv
